[src/pcfl_pkg.sv]
// ----------------------------------------------------------------------------
// pcfl_pkg
// Shared types and constants of the per-core page free-list allocator.
// ----------------------------------------------------------------------------
package pcfl_pkg;

  localparam int DEF_NUM_CORES = 8;
  localparam int DEF_NUM_PAGES = 4096;

  localparam int PAGE_W  = 12;
  localparam int LIMIT_W = 13;
  localparam int CORE_W  = 3;
  localparam int LINK_W  = PAGE_W + 1;

  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 13'd4096;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_LOWEST_VALID_PAGE = 1'b0;
  localparam logic REG_PAGE_LIMIT        = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FREED     = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  typedef struct packed {
    logic push;
    logic pop_adv;
    logic pop_empty;
  } head_op_t;

endpackage

[src/pcfl_link_mem.sv]
// ----------------------------------------------------------------------------
// pcfl_link_mem
// Next-link memory: one entry per page, one write and one registered read.
// ----------------------------------------------------------------------------
module pcfl_link_mem #(
  parameter int NUM_PAGES = pcfl_pkg::DEF_NUM_PAGES,
  parameter int AW = $clog2(NUM_PAGES)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pcfl_pkg::LINK_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pcfl_pkg::LINK_W-1:0] rdata
);

  logic [pcfl_pkg::LINK_W-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pcfl_heads.sv]
// ----------------------------------------------------------------------------
// pcfl_heads
// List heads and nonempty flags per core, with lowest-nonempty priority pick.
// ----------------------------------------------------------------------------
module pcfl_heads #(
  parameter int NUM_CORES = pcfl_pkg::DEF_NUM_CORES,
  parameter int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pcfl_pkg::head_op_t          op,
  input  logic [CW-1:0]               wr_core,
  input  logic [pcfl_pkg::PAGE_W-1:0] wr_page,
  input  logic [CW-1:0]               rd_core,
  output logic [pcfl_pkg::PAGE_W-1:0] rd_head,
  output logic [NUM_CORES-1:0]        nonempty,
  output logic [CW-1:0]               pick,
  output logic                        pick_valid
);

  logic [pcfl_pkg::PAGE_W-1:0] heads [NUM_CORES];

  always_ff @(posedge clk) begin
    if (op.push || op.pop_adv) begin
      heads[wr_core] <= wr_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (op.push) begin
      nonempty[wr_core] <= 1'b1;
    end else if (op.pop_empty) begin
      nonempty[wr_core] <= 1'b0;
    end
  end

  assign rd_head = heads[rd_core];

  // lowest-numbered nonempty list
  always_comb begin
    pick = '0;
    for (int i = NUM_CORES - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pick = CW'(i);
      end
    end
  end

  assign pick_valid = |nonempty;

endmodule

[src/per_core_page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// per_core_page_free_list_allocator
// Per-core LIFO page free lists linked through a next-link memory, with
// stealing from the lowest-numbered nonempty list when a core runs dry.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; action,
//   core and page are sampled at that edge. Each transaction gives exactly
//   one result, shown for one cycle with done high, on status,
//   granted_page and stolen; the receiver cannot hold results off.
//   A free, a rejected free and an allocate that finds no page return
//   their result in the cycle after acceptance, and a new transaction may
//   be taken in that same cycle.
//   A successful allocate reads the next link of the popped page from the
//   synchronous link memory, so busy is high for one cycle (S_POP) and the
//   result is registered from S_POP; the next transaction may be taken in the
//   cycle the result shows. Frees go one per cycle while busy is low; an
//   allocation holds off the next transaction until its link read is done.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   users make them only while no transaction is in flight; no check is made.
//   Reset (rst, synchronous) empties all lists and restores the registers
//   to a lowest valid page of 0 and a page limit of 4096.
// ----------------------------------------------------------------------------
module per_core_page_free_list_allocator #(
  parameter int NUM_CORES = pcfl_pkg::DEF_NUM_CORES,
  parameter int NUM_PAGES = pcfl_pkg::DEF_NUM_PAGES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [pcfl_pkg::CORE_W-1:0]  core,
  input  logic [pcfl_pkg::PAGE_W-1:0]  page,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [pcfl_pkg::PAGE_W-1:0]  granted_page,
  output logic                         stolen,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pcfl_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int CW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int CXW = (CW > pcfl_pkg::CORE_W) ? CW : pcfl_pkg::CORE_W;
  localparam int AW  = $clog2(NUM_PAGES);
  localparam int AXW = (AW > pcfl_pkg::PAGE_W) ? AW : pcfl_pkg::PAGE_W;

  pcfl_pkg::state_t state, state_next;

  logic [pcfl_pkg::PAGE_W-1:0]  lowest_valid_page;
  logic [pcfl_pkg::LIMIT_W-1:0] page_limit;

  logic [CW-1:0]               pop_core;
  logic [pcfl_pkg::PAGE_W-1:0] pop_page;
  logic                        pop_stolen;

  logic [CXW-1:0]              core_ext;
  logic [CW-1:0]               core_idx;
  logic                        core_in_range;
  logic                        accept;
  logic                        page_ok;
  logic                        free_ok;
  logic                        own_ok;
  logic                        alloc_ok;
  logic [CW-1:0]               sel_core;

  pcfl_pkg::head_op_t          head_op;
  logic [CW-1:0]               wr_core;
  logic [pcfl_pkg::PAGE_W-1:0] wr_page;
  logic [pcfl_pkg::PAGE_W-1:0] rd_head;
  logic [NUM_CORES-1:0]        nonempty;
  logic [CW-1:0]               pick;
  logic                        pick_valid;

  logic [AXW-1:0]              page_ext;
  logic [AXW-1:0]              head_ext;
  logic                        mem_we;
  logic                        mem_re;
  logic [pcfl_pkg::LINK_W-1:0] mem_wdata;
  logic [pcfl_pkg::LINK_W-1:0] mem_rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_valid_page <= '0;
      page_limit        <= pcfl_pkg::PAGE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcfl_pkg::REG_LOWEST_VALID_PAGE: lowest_valid_page <= cfg_data[pcfl_pkg::PAGE_W-1:0];
        pcfl_pkg::REG_PAGE_LIMIT:        page_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  // request decode
  assign core_ext      = CXW'(core);
  assign core_idx      = core_ext[CW-1:0];
  assign core_in_range = 32'(core) < 32'(NUM_CORES);
  assign accept        = start && !busy;

  assign page_ok  = (page >= lowest_valid_page) &&
                    (pcfl_pkg::LIMIT_W'(page) < page_limit) &&
                    (32'(page) < 32'(NUM_PAGES));
  assign free_ok  = core_in_range && page_ok;
  assign own_ok   = core_in_range && nonempty[core_idx];
  assign alloc_ok = own_ok || pick_valid;
  assign sel_core = (action == pcfl_pkg::ACT_FREE || own_ok) ? core_idx : pick;

  assign page_ext  = AXW'(page);
  assign head_ext  = AXW'(rd_head);
  assign mem_wdata = nonempty[core_idx] ? {1'b0, rd_head}
                                        : {1'b1, {pcfl_pkg::PAGE_W{1'b0}}};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pcfl_pkg::S_IDLE: begin
        if (accept && action == pcfl_pkg::ACT_ALLOC && alloc_ok) begin
          state_next = pcfl_pkg::S_POP;
        end
      end
      pcfl_pkg::S_POP: state_next = pcfl_pkg::S_IDLE;
      default: state_next = pcfl_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy    = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    head_op = '0;
    wr_core = core_idx;
    wr_page = page;
    case (state)
      pcfl_pkg::S_IDLE: begin
        if (accept && action == pcfl_pkg::ACT_FREE && free_ok) begin
          mem_we       = 1'b1;
          head_op.push = 1'b1;
        end
        if (accept && action == pcfl_pkg::ACT_ALLOC && alloc_ok) begin
          mem_re = 1'b1;
        end
      end
      pcfl_pkg::S_POP: begin
        busy    = 1'b1;
        wr_core = pop_core;
        wr_page = mem_rdata[pcfl_pkg::PAGE_W-1:0];
        if (mem_rdata[pcfl_pkg::PAGE_W]) begin
          head_op.pop_empty = 1'b1;
        end else begin
          head_op.pop_adv = 1'b1;
        end
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pop context
  always_ff @(posedge clk) begin
    if (mem_re) begin
      pop_core   <= sel_core;
      pop_page   <= rd_head;
      pop_stolen <= !own_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !(action == pcfl_pkg::ACT_ALLOC && alloc_ok)) ||
              (state == pcfl_pkg::S_POP);
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcfl_pkg::S_POP) begin
      status       <= pcfl_pkg::ST_ALLOCATED;
      granted_page <= pop_page;
      stolen       <= pop_stolen;
    end else begin
      granted_page <= '0;
      stolen       <= 1'b0;
      if (action == pcfl_pkg::ACT_FREE) begin
        status <= free_ok ? pcfl_pkg::ST_FREED : pcfl_pkg::ST_INVALID;
      end else begin
        status <= pcfl_pkg::ST_NO_MEMORY;
      end
    end
  end

  pcfl_heads #(
    .NUM_CORES (NUM_CORES),
    .CW        (CW)
  ) u_heads (
    .clk        (clk),
    .rst        (rst),
    .op         (head_op),
    .wr_core    (wr_core),
    .wr_page    (wr_page),
    .rd_core    (sel_core),
    .rd_head    (rd_head),
    .nonempty   (nonempty),
    .pick       (pick),
    .pick_valid (pick_valid)
  );

  pcfl_link_mem #(
    .NUM_PAGES (NUM_PAGES),
    .AW        (AW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (page_ext[AW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head_ext[AW-1:0]),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("pop held busy for more than one cycle");

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && status == pcfl_pkg::ST_ALLOCATED)
    else $error("pop did not deliver an allocated result");

  a_pop_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == pcfl_pkg::S_POP |-> nonempty[pop_core])
    else $error("pop from an empty list");

  a_unused_fields_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != pcfl_pkg::ST_ALLOCATED |-> granted_page == '0 && !stolen)
    else $error("granted_page or stolen set without an allocation");
`endif

endmodule
